// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on a clock, off during reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cbq_pkg.sv
package cbq_pkg;

  localparam int MaxSectionsDef = 8;
  localparam int CoefsPerSec    = 5;
  localparam int SampleW        = 16;
  localparam int CoefW          = 16;
  localparam int DelayW         = 32;
  localparam int IdxW           = 6;
  localparam int CountW         = 4;
  localparam int ProdW          = DelayW + CoefW;
  localparam int FracShift      = 14;
  localparam int OutShift       = 8;
  localparam int AccW           = 37;
  localparam int StepW          = 3;

  localparam logic [CountW-1:0] SectionCountRst = CountW'(1);

  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [SampleW-1:0] sample_in;
    logic [IdxW-1:0]           coef_index;
    logic signed [CoefW-1:0]   coef_value;
    logic                      end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      last_of_block;
  } out_item_t;

  // coefficient order inside a section
  typedef enum logic [2:0] {
    POS_A1 = 3'd0,
    POS_A2 = 3'd1,
    POS_B2 = 3'd2,
    POS_B0 = 3'd3,
    POS_B1 = 3'd4
  } coef_pos_e;

  typedef enum logic {
    SLOT_W1,
    SLOT_W2
  } slot_e;

  typedef enum logic [1:0] {
    SRC_DLY,
    SRC_W1,
    SRC_W2,
    SRC_W0
  } mul_src_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_OUT
  } seq_e;

  typedef struct packed {
    coef_pos_e coef_pos;
    slot_e     slot;
    logic      ld_w1;
    logic      ld_w2;
    logic      mul_en;
    mul_src_e  mul_src;
    acc_op_e   acc_op;
    logic      w0_ld;
    logic      dly_wr;
    seq_e      seq;
  } ucode_t;

  typedef struct packed {
    logic   start;
    logic   coef_wr;
    logic   emit;
    ucode_t uc;
  } dp_cmd_t;

  localparam ucode_t UC_NOP = '{
    coef_pos: POS_A1, slot: SLOT_W1, ld_w1: 1'b0, ld_w2: 1'b0, mul_en: 1'b0,
    mul_src: SRC_DLY, acc_op: ACC_HOLD, w0_ld: 1'b0, dly_wr: 1'b0, seq: SEQ_NEXT
  };

  localparam logic [StepW-1:0] STEP_RD_W1  = StepW'(0);
  localparam logic [StepW-1:0] STEP_RD_W2  = StepW'(1);
  localparam logic [StepW-1:0] STEP_SUB_A1 = StepW'(2);
  localparam logic [StepW-1:0] STEP_SUB_A2 = StepW'(3);
  localparam logic [StepW-1:0] STEP_W0     = StepW'(4);
  localparam logic [StepW-1:0] STEP_ADD_B1 = StepW'(5);
  localparam logic [StepW-1:0] STEP_ADD_B0 = StepW'(6);
  localparam logic [StepW-1:0] STEP_OUT    = StepW'(7);

  // One section program. Memory reads return in the cycle after the address.
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t uc;
    uc = UC_NOP;
    case (step)
      STEP_RD_W1: begin
        uc.coef_pos = POS_A1;
        uc.slot     = SLOT_W1;
      end
      STEP_RD_W2: begin
        uc.coef_pos = POS_A2;
        uc.slot     = SLOT_W2;
        uc.ld_w1    = 1'b1;
        uc.mul_en   = 1'b1;
        uc.mul_src  = SRC_DLY;
      end
      STEP_SUB_A1: begin
        uc.coef_pos = POS_B2;
        uc.ld_w2    = 1'b1;
        uc.mul_en   = 1'b1;
        uc.mul_src  = SRC_DLY;
        uc.acc_op   = ACC_SUB;
      end
      STEP_SUB_A2: begin
        uc.coef_pos = POS_B1;
        uc.mul_en   = 1'b1;
        uc.mul_src  = SRC_W2;
        uc.acc_op   = ACC_SUB;
      end
      STEP_W0: begin
        uc.coef_pos = POS_B0;
        uc.mul_en   = 1'b1;
        uc.mul_src  = SRC_W1;
        uc.acc_op   = ACC_LOAD;
        uc.w0_ld    = 1'b1;
      end
      STEP_ADD_B1: begin
        uc.mul_en   = 1'b1;
        uc.mul_src  = SRC_W0;
        uc.acc_op   = ACC_ADD;
        uc.dly_wr   = 1'b1;
      end
      STEP_ADD_B0: begin
        uc.acc_op   = ACC_ADD;
        uc.seq      = SEQ_LOOP;
      end
      STEP_OUT: begin
        uc.seq      = SEQ_OUT;
      end
      default: begin
        uc = UC_NOP;
      end
    endcase
    return uc;
  endfunction

endpackage

// File: rtl/cbq_datapath.sv
`include "assert_macros.svh"

module cbq_datapath
  import cbq_pkg::*;
#(
  parameter int MAX_SECTIONS = MaxSectionsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  input  in_item_t                  item_i,
  input  logic [CountW-1:0]         section_count_i,
  output logic                      more_sec_o,
  output logic signed [SampleW-1:0] sample_o
);

  localparam int NsW       = $clog2(MAX_SECTIONS + 1);
  localparam int SecW      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int DlyDepth  = 2 * MAX_SECTIONS;
  localparam int DAW       = $clog2(DlyDepth);
  localparam int CoefDepth = CoefsPerSec * MAX_SECTIONS;
  localparam int CAW       = $clog2(CoefDepth);
  localparam int CmpW      = ((IdxW > CAW) ? IdxW : CAW) + 1;
  localparam int CntCmpW   = (CountW > NsW) ? CountW : NsW;
  localparam int ShpW      = ProdW - FracShift;

  // sequencing state
  logic [NsW-1:0]  ns_q;
  logic [SecW-1:0] sec_q;
  logic [CAW-1:0]  base_q;
  logic            phase_q;
  logic [NsW-1:0]  ns_d;

  // coefficient store
  logic signed [CoefW-1:0] coef_mem [CoefDepth];
  logic [CoefDepth-1:0]    coef_vld_q;
  logic signed [CoefW-1:0] coef_rd_q;
  logic                    coef_rv_q;
  logic [CAW-1:0]          coef_wr_addr;
  logic [CAW-1:0]          coef_rd_addr;
  logic                    coef_we;
  logic signed [CoefW-1:0] coef_val;

  // delay store
  logic signed [DelayW-1:0] dly_mem [DlyDepth];
  logic [DlyDepth-1:0]      dly_vld_q;
  logic signed [DelayW-1:0] dly_rd_q;
  logic                     dly_rv_q;
  logic [DAW-1:0]           slot_lo;
  logic [DAW-1:0]           slot_hi;
  logic [DAW-1:0]           w1_slot;
  logic [DAW-1:0]           w2_slot;
  logic [DAW-1:0]           dly_rd_addr;
  logic signed [DelayW-1:0] dly_val;

  // arithmetic
  logic signed [DelayW-1:0] w1_q;
  logic signed [DelayW-1:0] w2_q;
  logic signed [DelayW-1:0] w0_q;
  logic signed [DelayW-1:0] w0_d;
  logic signed [DelayW-1:0] mul_a;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ProdW-1:0]  prod_d;
  logic signed [AccW-1:0]   acc_q;
  logic signed [AccW-1:0]   acc_d;
  logic signed [AccW-1:0]   shp;
  logic signed [AccW-1:0]   tr;
  logic [AccW-SampleW-OutShift:0] tr_top;

  assign ns_d = (CntCmpW'(section_count_i) > CntCmpW'(MAX_SECTIONS)) ?
                NsW'(MAX_SECTIONS) : NsW'(section_count_i);

  assign more_sec_o = ((NsW+1)'(sec_q) + (NsW+1)'(1)) < (NsW+1)'(ns_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q    <= '0;
      sec_q   <= '0;
      base_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        ns_q   <= ns_d;
        sec_q  <= '0;
        base_q <= '0;
      end else if (cmd_i.uc.seq == SEQ_LOOP && more_sec_o) begin
        sec_q  <= sec_q + SecW'(1);
        base_q <= base_q + CAW'(CoefsPerSec);
      end
      if (cmd_i.emit) begin
        phase_q <= ~phase_q;
      end
    end
  end

  // ---- coefficient store ----
  assign coef_wr_addr = CAW'(item_i.coef_index);
  assign coef_we      = cmd_i.coef_wr &&
                        (CmpW'(item_i.coef_index) < CmpW'(CoefDepth));
  assign coef_rd_addr = base_q + CAW'(cmd_i.uc.coef_pos);

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wr_addr] <= item_i.coef_value;
    end
    coef_rd_q <= coef_mem[coef_rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      coef_rv_q  <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld_q[coef_wr_addr] <= 1'b1;
      end
      coef_rv_q <= coef_vld_q[coef_rd_addr];
    end
  end

  assign coef_val = coef_rv_q ? coef_rd_q : '0;

  // ---- delay store: halves swap roles with the phase ----
  assign slot_lo     = DAW'(sec_q);
  assign slot_hi     = DAW'(ns_q) + DAW'(sec_q);
  assign w1_slot     = phase_q ? slot_hi : slot_lo;
  assign w2_slot     = phase_q ? slot_lo : slot_hi;
  assign dly_rd_addr = (cmd_i.uc.slot == SLOT_W1) ? w1_slot : w2_slot;

  always_ff @(posedge clk_i) begin
    if (cmd_i.uc.dly_wr) begin
      dly_mem[w2_slot] <= w0_q;
    end
    dly_rd_q <= dly_mem[dly_rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_vld_q <= '0;
      dly_rv_q  <= 1'b0;
    end else begin
      if (cmd_i.uc.dly_wr) begin
        dly_vld_q[w2_slot] <= 1'b1;
      end
      dly_rv_q <= dly_vld_q[dly_rd_addr];
    end
  end

  assign dly_val = dly_rv_q ? dly_rd_q : '0;

  // ---- multiply / accumulate ----
  always_comb begin
    case (cmd_i.uc.mul_src)
      SRC_DLY: mul_a = dly_val;
      SRC_W1:  mul_a = w1_q;
      SRC_W2:  mul_a = w2_q;
      SRC_W0:  mul_a = w0_q;
      default: mul_a = dly_val;
    endcase
  end

  assign prod_d = mul_a * coef_val;

  // product >> 14, floor
  assign shp = {{(AccW-ShpW){prod_q[ProdW-1]}}, prod_q[ProdW-1:FracShift]};

  always_comb begin
    case (cmd_i.uc.acc_op)
      ACC_LOAD: acc_d = shp;
      ACC_SUB:  acc_d = acc_q - shp;
      ACC_ADD:  acc_d = acc_q + shp;
      default:  acc_d = acc_q;
    endcase
    if (cmd_i.start) begin
      acc_d = {{(AccW-SampleW-OutShift){item_i.sample_in[SampleW-1]}},
               item_i.sample_in, {OutShift{1'b0}}};
    end
  end

  // w0 saturates to 32 bits
  always_comb begin
    if ((&acc_q[AccW-1:DelayW-1]) || !(|acc_q[AccW-1:DelayW-1])) begin
      w0_d = acc_q[DelayW-1:0];
    end else if (acc_q[AccW-1]) begin
      w0_d = {1'b1, {(DelayW-1){1'b0}}};
    end else begin
      w0_d = {1'b0, {(DelayW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.uc.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.uc.ld_w1) begin
      w1_q <= dly_val;
    end
    if (cmd_i.uc.ld_w2) begin
      w2_q <= dly_val;
    end
    if (cmd_i.uc.w0_ld) begin
      w0_q <= w0_d;
    end
  end

  // output: y >> 8 toward zero, then clamp to 16 bits
  assign tr     = acc_q + (acc_q[AccW-1] ? AccW'(255) : AccW'(0));
  assign tr_top = tr[AccW-1:SampleW+OutShift-1];

  always_comb begin
    if ((&tr_top) || !(|tr_top)) begin
      sample_o = tr[SampleW+OutShift-1:OutShift];
    end else if (tr[AccW-1]) begin
      sample_o = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      sample_o = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  `ASSERT_AT(a_wr_after_w0, clk_i, rst_ni, cmd_i.uc.dly_wr |-> $past(cmd_i.uc.w0_ld), "delay write without fresh w0")
  `ASSERT_AT(a_phase_on_emit, clk_i, rst_ni, (phase_q != $past(phase_q)) |-> $past(cmd_i.emit), "phase moved without a result")

endmodule

// File: rtl/cascaded_biquad_iir_filter_core.sv
// Cascaded direct-form-II biquad filter, 16-bit samples, Q2.14 coefficients.
// Input channel (in_valid_i / in_stall_o / in_data_i): func 0 filters one
// sample and yields one result; func 1 writes one coefficient slot (slots past
// the last of MAX_SECTIONS sections are dropped) and yields nothing.
// Output channel (out_valid_o / out_stall_i / out_data_o): one filtered sample
// per filter transaction, with end_of_block copied to last_of_block.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): section count,
// always ready, write it only while the block is idle.
// Timing: a coefficient write completes as it is accepted. A filter
// transaction with N active sections runs the microcode steps of each section
// in turn, then the final step loads the result register; the input stalls
// until that load. The steps per section come from the one shared 32x16
// multiplier fed by single-read-port stores.
// Stall: the result register holds until taken; a new transaction is taken
// while it waits, but the next result waits in the final step for it to drain.
// Reset: all coefficients and delay values read as zero, ping-pong phase 0,
// section count 1. No clearing pass is needed.
`include "assert_macros.svh"

module cascaded_biquad_iir_filter_core
  import cbq_pkg::*;
#(
  parameter int MAX_SECTIONS = MaxSectionsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  logic              busy_q, busy_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CountW-1:0] section_count_q;
  logic              out_valid_q;
  out_item_t         out_data_q;
  logic              eob_q;
  logic              in_accept;
  logic              more_sec;
  logic signed [SampleW-1:0] dp_sample;
  dp_cmd_t           cmd;

  assign in_stall_o  = busy_q;
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_comb begin
    cmd.uc      = busy_q ? ucode_rom(step_q) : UC_NOP;
    cmd.start   = in_accept && (in_data_i.func == FUNC_FILTER);
    cmd.coef_wr = in_accept && (in_data_i.func == FUNC_COEF);
    cmd.emit    = busy_q && (cmd.uc.seq == SEQ_OUT) && (!out_valid_q || !out_stall_i);
  end

  // step counter with the loop jump from the microcode
  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    if (cmd.start) begin
      busy_d = 1'b1;
      step_d = (section_count_q == '0) ? STEP_OUT : STEP_RD_W1;
    end else if (busy_q) begin
      case (cmd.uc.seq)
        SEQ_NEXT: step_d = step_q + StepW'(1);
        SEQ_LOOP: step_d = more_sec ? STEP_RD_W1 : STEP_OUT;
        SEQ_OUT: begin
          if (cmd.emit) begin
            busy_d = 1'b0;
          end
        end
        default: step_d = step_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q          <= 1'b0;
      step_q          <= STEP_RD_W1;
      section_count_q <= SectionCountRst;
      out_valid_q     <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (cfg_valid_i && cfg_ready_o) begin
        section_count_q <= cfg_data_i;
      end
      if (cmd.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.start) begin
      eob_q <= in_data_i.end_of_block;
    end
    if (cmd.emit) begin
      out_data_q.sample_out    <= dp_sample;
      out_data_q.last_of_block <= eob_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  cbq_datapath #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (in_data_i),
    .section_count_i(section_count_q),
    .more_sec_o     (more_sec),
    .sample_o       (dp_sample)
  );

  `ASSERT_AT(a_no_overwrite, clk_i, rst_ni, cmd.emit |-> (!out_valid_q || !out_stall_i), "pending result overwritten")
  `ASSERT_AT(a_out_from_seq, clk_i, rst_ni, $rose(out_valid_q) |-> $past(busy_q && step_q == STEP_OUT), "result outside final step")
  `ASSERT_NEXT(a_idle_after_emit, clk_i, rst_ni, cmd.emit, !busy_q, "sequencer still busy after result")

endmodule
